>>> design/imu_pvi_pkg.sv
// Package for the IMU position/velocity integrator.
// Holds the sequencer step type, the lane control struct, register indexes,
// reset values and the saturation helper. No dependencies.
`default_nettype none

package imu_pvi_pkg;

  // Config register indexes
  localparam logic [2:0] REG_ROT_ROW0  = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1  = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2  = 3'd2;
  localparam logic [2:0] REG_BIAS      = 3'd3;
  localparam logic [2:0] REG_GRAVITY   = 3'd4;
  localparam logic [2:0] REG_TICK      = 3'd5;

  localparam logic [47:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST = 48'h4000_0000_0000;
  localparam logic [47:0] BIAS_RST     = 48'h0;
  localparam logic [15:0] GRAVITY_RST  = 16'd2511;
  localparam logic [31:0] TICK_RST     = 32'd4295;

  localparam logic [31:0] DT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICKS,
    ST_DT,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_ACC,
    ST_VDT,
    ST_ADV,
    ST_HALF,
    ST_SUM,
    ST_UPD
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load;    // input transfer this cycle
    logic  commit;  // state update and output capture this cycle
  } ctrl_t;

  // Clamp a 36-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x[35:31] == 5'b00000 || x[35:31] == 5'b11111) begin
      r = x[31:0];
    end else if (x[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/imu_pvi_dt.sv
// Time step unit: tick difference against the stored timestamp and dt scaling.
// Depends on imu_pvi_pkg (ctrl_t, step codes, DT_MAX).
`default_nettype none

module imu_pvi_dt (
  input  wire                 clk,
  input  wire                 rst,
  input  imu_pvi_pkg::ctrl_t  ctrl,
  input  wire  [63:0]         sample_time,
  input  wire  [31:0]         tick_period,
  output logic [31:0]         dt
);

  logic [63:0] t_in;
  logic [63:0] last_time;
  logic        time_seen;
  logic [31:0] ticks;
  logic [31:0] ticks_next;
  logic [63:0] diff;
  logic [63:0] prod;

  assign diff = t_in - last_time;
  assign prod = ticks * tick_period;

  always_comb begin
    if (!time_seen || t_in < last_time) begin
      ticks_next = '0;
    end else if (diff[63:32] != 32'd0) begin
      ticks_next = imu_pvi_pkg::DT_MAX;
    end else begin
      ticks_next = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      time_seen <= 1'b0;
    end else if (ctrl.step == imu_pvi_pkg::ST_TICKS) begin
      last_time <= t_in;
      time_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      t_in <= sample_time;
    end
    if (ctrl.step == imu_pvi_pkg::ST_TICKS) begin
      ticks <= ticks_next;
    end
    if (ctrl.step == imu_pvi_pkg::ST_DT) begin
      dt <= (prod[63:32] != 32'd0) ? imu_pvi_pkg::DT_MAX : prod[31:0];
    end
  end

endmodule

`default_nettype wire

>>> design/imu_pvi_lane.sv
// One world axis: matrix row dot product, gravity, and p/v integration.
// A single registered multiplier is stepped by the shared sequencer.
// Depends on imu_pvi_pkg (ctrl_t, step codes, sat32).
`default_nettype none

module imu_pvi_lane (
  input  wire                 clk,
  input  wire                 rst,
  input  imu_pvi_pkg::ctrl_t  ctrl,
  input  wire  [47:0]         row,
  input  wire  signed [16:0]  u_x,
  input  wire  signed [16:0]  u_y,
  input  wire  signed [16:0]  u_z,
  input  wire  [15:0]         grav,   // zero on the horizontal axes
  input  wire  [31:0]         dt,
  output logic signed [31:0]  pos_new,
  output logic signed [31:0]  vel_new
);

  logic signed [31:0] pos;
  logic signed [31:0] vel;
  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] mul;
  logic signed [35:0] acc;
  logic signed [35:0] w;
  logic signed [29:0] accel;
  logic signed [48:0] vdt;
  logic signed [29:0] adv;
  logic signed [29:0] adv_w;
  logic signed [43:0] half_w;
  logic signed [51:0] p_sum;
  logic signed [35:0] v_sum;

  assign adv_w  = mul[61:32];
  assign half_w = mul[60:17];
  assign w      = acc + mul[35:0] - {6'b0, grav, 14'b0};
  assign p_sum  = {{4{pos[31]}}, pos, 16'b0} + {{3{vdt[48]}}, vdt}
                + {{8{half_w[43]}}, half_w};
  assign v_sum  = {{4{vel[31]}}, vel} + {{6{adv[29]}}, adv};

  always_comb begin
    case (ctrl.step)
      imu_pvi_pkg::ST_MAC0: begin
        opa = {{17{row[15]}}, row[15:0]};
        opb = {{16{u_x[16]}}, u_x};
      end
      imu_pvi_pkg::ST_MAC1: begin
        opa = {{17{row[31]}}, row[31:16]};
        opb = {{16{u_y[16]}}, u_y};
      end
      imu_pvi_pkg::ST_MAC2: begin
        opa = {{17{row[47]}}, row[47:32]};
        opb = {{16{u_z[16]}}, u_z};
      end
      imu_pvi_pkg::ST_VDT: begin
        opa = {vel[31], vel};
        opb = {1'b0, dt};
      end
      imu_pvi_pkg::ST_ADV: begin
        opa = {{3{accel[29]}}, accel};
        opb = {1'b0, dt};
      end
      imu_pvi_pkg::ST_HALF: begin
        opa = {{3{adv_w[29]}}, adv_w};
        opb = {1'b0, dt};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul <= opa * opb;
    case (ctrl.step)
      imu_pvi_pkg::ST_MAC1: acc <= mul[35:0];
      imu_pvi_pkg::ST_MAC2: acc <= acc + mul[35:0];
      imu_pvi_pkg::ST_ACC:  accel <= w[35:6];       // floor divide by 2^6
      imu_pvi_pkg::ST_ADV:  vdt <= mul[64:16];
      imu_pvi_pkg::ST_HALF: adv <= adv_w;
      imu_pvi_pkg::ST_SUM: begin
        pos_new <= imu_pvi_pkg::sat32(p_sum[51:16]);
        vel_new <= imu_pvi_pkg::sat32(v_sum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctrl.commit) begin
      pos <= pos_new;
      vel <= vel_new;
    end
  end

endmodule

`default_nettype wire

>>> design/imu_position_velocity_integrator_unit.sv
// Sequence: after an input transfer each lane runs its multiply sequence on
// its single multiplier; UPD commits, and waits while the output is full.
// A new sample is taken only in IDLE, once the previous one has committed.
// Reset: synchronous; clears position, velocity and timestamp state and loads
// the register defaults. No clearing pass.
`default_nettype none

module imu_position_velocity_integrator_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [47:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [63:0]        sample_time,
  input  wire  signed [15:0] accel_x,
  input  wire  signed [15:0] accel_y,
  input  wire  signed [15:0] accel_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z
);

  imu_pvi_pkg::step_t state;
  imu_pvi_pkg::step_t state_next;
  imu_pvi_pkg::ctrl_t ctrl;

  logic [47:0] rot_row0;
  logic [47:0] rot_row1;
  logic [47:0] rot_row2;
  logic [47:0] accel_bias;
  logic [15:0] gravity_magnitude;
  logic [31:0] tick_period;

  logic signed [16:0] u_x;
  logic signed [16:0] u_y;
  logic signed [16:0] u_z;
  logic [31:0]        dt;
  logic signed [31:0] pn_x, pn_y, pn_z;
  logic signed [31:0] vn_x, vn_y, vn_z;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0          <= imu_pvi_pkg::ROT_ROW0_RST;
      rot_row1          <= imu_pvi_pkg::ROT_ROW1_RST;
      rot_row2          <= imu_pvi_pkg::ROT_ROW2_RST;
      accel_bias        <= imu_pvi_pkg::BIAS_RST;
      gravity_magnitude <= imu_pvi_pkg::GRAVITY_RST;
      tick_period       <= imu_pvi_pkg::TICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        imu_pvi_pkg::REG_ROT_ROW0: rot_row0          <= cfg_data;
        imu_pvi_pkg::REG_ROT_ROW1: rot_row1          <= cfg_data;
        imu_pvi_pkg::REG_ROT_ROW2: rot_row2          <= cfg_data;
        imu_pvi_pkg::REG_BIAS:     accel_bias        <= cfg_data;
        imu_pvi_pkg::REG_GRAVITY:  gravity_magnitude <= cfg_data[15:0];
        imu_pvi_pkg::REG_TICK:     tick_period       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imu_pvi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctrl.step   = state;
    ctrl.load   = 1'b0;
    ctrl.commit = 1'b0;
    case (state)
      imu_pvi_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        if (in_valid) state_next = imu_pvi_pkg::ST_TICKS;
      end
      imu_pvi_pkg::ST_TICKS: state_next = imu_pvi_pkg::ST_DT;
      imu_pvi_pkg::ST_DT:    state_next = imu_pvi_pkg::ST_MAC0;
      imu_pvi_pkg::ST_MAC0:  state_next = imu_pvi_pkg::ST_MAC1;
      imu_pvi_pkg::ST_MAC1:  state_next = imu_pvi_pkg::ST_MAC2;
      imu_pvi_pkg::ST_MAC2:  state_next = imu_pvi_pkg::ST_ACC;
      imu_pvi_pkg::ST_ACC:   state_next = imu_pvi_pkg::ST_VDT;
      imu_pvi_pkg::ST_VDT:   state_next = imu_pvi_pkg::ST_ADV;
      imu_pvi_pkg::ST_ADV:   state_next = imu_pvi_pkg::ST_HALF;
      imu_pvi_pkg::ST_HALF:  state_next = imu_pvi_pkg::ST_SUM;
      imu_pvi_pkg::ST_SUM:   state_next = imu_pvi_pkg::ST_UPD;
      imu_pvi_pkg::ST_UPD: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          ctrl.commit = 1'b1;
          state_next  = imu_pvi_pkg::ST_IDLE;
        end
      end
      default: state_next = imu_pvi_pkg::ST_IDLE;
    endcase
  end

  // Bias-corrected body acceleration, Q8.8 in 17 bits
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      u_x <= {accel_x[15], accel_x} - {accel_bias[15], accel_bias[15:0]};
      u_y <= {accel_y[15], accel_y} - {accel_bias[31], accel_bias[31:16]};
      u_z <= {accel_z[15], accel_z} - {accel_bias[47], accel_bias[47:32]};
    end
  end

  imu_pvi_dt u_dt (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sample_time (sample_time),
    .tick_period (tick_period),
    .dt          (dt)
  );

  imu_pvi_lane u_lane_x (
    .clk (clk), .rst (rst), .ctrl (ctrl), .row (rot_row0),
    .u_x (u_x), .u_y (u_y), .u_z (u_z), .grav (16'd0), .dt (dt),
    .pos_new (pn_x), .vel_new (vn_x)
  );

  imu_pvi_lane u_lane_y (
    .clk (clk), .rst (rst), .ctrl (ctrl), .row (rot_row1),
    .u_x (u_x), .u_y (u_y), .u_z (u_z), .grav (16'd0), .dt (dt),
    .pos_new (pn_y), .vel_new (vn_y)
  );

  imu_pvi_lane u_lane_z (
    .clk (clk), .rst (rst), .ctrl (ctrl), .row (rot_row2),
    .u_x (u_x), .u_y (u_y), .u_z (u_z), .grav (gravity_magnitude), .dt (dt),
    .pos_new (pn_z), .vel_new (vn_z)
  );

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      pos_x <= pn_x;
      pos_y <= pn_y;
      pos_z <= pn_z;
      vel_x <= vn_x;
      vel_y <= vn_y;
      vel_z <= vn_z;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == imu_pvi_pkg::ST_UPD && out_valid && !out_ready)
      |=> (state == imu_pvi_pkg::ST_UPD))
    else $error("result update ran over a pending transfer");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == imu_pvi_pkg::ST_TICKS))
    else $error("input transfer did not start the sequence");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == imu_pvi_pkg::ST_UPD))
    else $error("out_valid rose without a commit");

endmodule

`default_nettype wire
